>>> rtl/stuffed_serial_link_engine_unit_assert.svh
// Assertion macros for the serial link engine.
// Expects clk and arst_n in the scope of the using module.
`ifndef STUFFED_SERIAL_LINK_ENGINE_UNIT_ASSERT_SVH
`define STUFFED_SERIAL_LINK_ENGINE_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define SSLU_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SSLU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SSLU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sslu_pkg.sv
// Shared types, constants and byte-coding functions of the serial link engine.
// No dependencies.
`default_nettype none
package sslu_pkg;

	localparam int RING_DEPTH_DEF    = 32;
	localparam int TIMEOUT_TICKS_DEF = 4;

	localparam int BYTE_W = 8;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;
	localparam int LVL_W  = 5;
	localparam int IDLE_W = 3;

	localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OP_W-1:0] OP_POP   = 3'd1;
	localparam logic [OP_W-1:0] OP_XCHG  = 3'd2;
	localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY_ERR = 2'd3;

	localparam logic [BYTE_W-1:0] IDLE_BYTE    = 8'hAC;
	localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'hCA;
	localparam logic [BYTE_W-1:0] XOR_MASK     = 8'hC0;
	localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'h00;
	localparam logic [BYTE_W-1:0] ONES_BYTE    = 8'hFF;
	localparam logic [BYTE_W-1:0] FLAG_TIMEOUT = 8'h80;
	localparam logic [BYTE_W-1:0] FLAG_LINE    = 8'h40;
	localparam logic [BYTE_W-1:0] FLAG_OVF     = 8'h01;

	localparam logic [IDLE_W-1:0] IDLE_MAX = 3'd7;

	typedef enum logic [1:0] {
		SRC_DIRECT,
		SRC_RX,
		SRC_TX
	} out_src_t;

	typedef struct packed {
		out_src_t          src;
		logic [BYTE_W-1:0] direct;
		logic [ST_W-1:0]   status;
		logic [BYTE_W-1:0] flags;
		logic              start;
		logic [LVL_W-1:0]  rx_level;
		logic [LVL_W-1:0]  tx_level;
	} s1_t;

	function automatic logic is_reserved(input logic [BYTE_W-1:0] enc);
		return (enc == IDLE_BYTE) || (enc == ESC_BYTE) || (enc == ONES_BYTE) ||
			(enc == ZERO_BYTE);
	endfunction

	function automatic logic [BYTE_W-1:0] tx_encode(input logic [BYTE_W-1:0] raw);
		logic [BYTE_W-1:0] enc;
		enc = raw ^ XOR_MASK;
		return is_reserved(enc) ? ESC_BYTE : enc;
	endfunction

endpackage
`default_nettype wire

>>> rtl/sslu_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on sslu_pkg.
`default_nettype none
interface sslu_cmd_if;
	import sslu_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [BYTE_W-1:0] data_byte;
	logic              transfer_busy;
	modport source(output valid, opcode, data_byte, transfer_busy, input ready);
	modport sink(input valid, opcode, data_byte, transfer_busy, output ready);
endinterface

interface sslu_rsp_if;
	import sslu_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic [ST_W-1:0]   status;
	logic [BYTE_W-1:0] error_flags;
	logic              start_transfer;
	logic [LVL_W-1:0]  rx_level;
	logic [LVL_W-1:0]  tx_level;
	modport source(output valid, out_byte, status, error_flags, start_transfer,
		rx_level, tx_level, input ready);
	modport sink(input valid, out_byte, status, error_flags, start_transfer,
		rx_level, tx_level, output ready);
endinterface
`default_nettype wire

>>> rtl/sslu_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module sslu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/sslu_ctrl.sv
// Accept stage: ring pointers, flags, escape and timeout state; issues ring accesses.
// Depends on sslu_pkg, sslu_if and the assertion header.
`default_nettype none
module sslu_ctrl #(
	parameter int RING_DEPTH    = sslu_pkg::RING_DEPTH_DEF,
	parameter int TIMEOUT_TICKS = sslu_pkg::TIMEOUT_TICKS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sslu_cmd_if.sink                           cmd,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_wdata,
	input  wire logic                          s1_take,
	input  wire logic [sslu_pkg::BYTE_W-1:0]   tx_rdata,
	output      logic                          tx_we,
	output      logic [$clog2(RING_DEPTH)-1:0] tx_waddr,
	output      logic                          tx_re,
	output      logic [$clog2(RING_DEPTH)-1:0] tx_raddr,
	output      logic                          rx_we,
	output      logic [$clog2(RING_DEPTH)-1:0] rx_waddr,
	output      logic [sslu_pkg::BYTE_W-1:0]   rx_wdata,
	output      logic                          rx_re,
	output      logic [$clog2(RING_DEPTH)-1:0] rx_raddr,
	output      logic                          s1_valid,
	output      sslu_pkg::s1_t                 s1_s1
);
	import sslu_pkg::*;
	`include "stuffed_serial_link_engine_unit_assert.svh"

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] CNT_FULL = AW'(RING_DEPTH - 1);
	localparam logic [IDLE_W-1:0] IDLE_LIMIT = IDLE_W'(TIMEOUT_TICKS);

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == CNT_FULL) ? '0 : p + 1'b1;
	endfunction

	logic [AW-1:0]     tx_wptr_q, tx_rptr_q, tx_cnt_q;
	logic [AW-1:0]     rx_wptr_q, rx_rptr_q, rx_cnt_q;
	logic [BYTE_W-1:0] hold_q, flags_q;
	logic              armed_q, act_q, role_q;
	logic [IDLE_W-1:0] idle_q;

	logic [AW-1:0]     tx_wptr_d, tx_rptr_d, tx_cnt_d;
	logic [AW-1:0]     rx_wptr_d, rx_rptr_d, rx_cnt_d;
	logic [BYTE_W-1:0] hold_d, flags_d;
	logic              armed_d, act_d;
	logic [IDLE_W-1:0] idle_d;
	s1_t               s1_d;

	logic              acc;
	logic              esc_fwd;
	logic [BYTE_W-1:0] hold_eff;

	assign cmd.ready = !s1_valid || s1_take;
	assign acc       = cmd.valid && cmd.ready;
	// escape byte from a pop still in flight is forwarded
	assign esc_fwd   = s1_valid && (s1_s1.src == SRC_TX) && is_reserved(tx_rdata ^ XOR_MASK);
	assign hold_eff  = esc_fwd ? ~tx_rdata : hold_q;

	assign tx_waddr = tx_wptr_q;
	assign tx_raddr = tx_rptr_q;
	assign rx_waddr = rx_wptr_q;
	assign rx_raddr = rx_rptr_q;

	always_comb begin
		logic              store;
		logic [BYTE_W-1:0] v;
		store     = 1'b0;
		v         = cmd.data_byte ^ XOR_MASK;
		tx_wptr_d = tx_wptr_q;
		tx_rptr_d = tx_rptr_q;
		tx_cnt_d  = tx_cnt_q;
		rx_wptr_d = rx_wptr_q;
		rx_rptr_d = rx_rptr_q;
		rx_cnt_d  = rx_cnt_q;
		hold_d    = (esc_fwd && s1_take) ? ~tx_rdata : hold_q;
		flags_d   = flags_q;
		armed_d   = armed_q;
		act_d     = act_q;
		idle_d    = idle_q;
		tx_we     = 1'b0;
		tx_re     = 1'b0;
		rx_we     = 1'b0;
		rx_re     = 1'b0;
		s1_d.src    = SRC_DIRECT;
		s1_d.direct = '0;
		s1_d.status = ST_OK;
		s1_d.start  = 1'b0;
		if (acc) begin
			unique case (cmd.opcode)
				OP_PUSH: begin
					if (tx_cnt_q == CNT_FULL) begin
						s1_d.status = ST_FULL;
					end else begin
						tx_we     = 1'b1;
						tx_wptr_d = ptr_next(tx_wptr_q);
						tx_cnt_d  = tx_cnt_q + 1'b1;
					end
				end
				OP_POP: begin
					if (rx_cnt_q == '0) begin
						s1_d.direct = flags_q;
						s1_d.status = (flags_q != '0) ? ST_EMPTY_ERR : ST_EMPTY;
					end else begin
						rx_re     = 1'b1;
						s1_d.src  = SRC_RX;
						rx_rptr_d = ptr_next(rx_rptr_q);
						rx_cnt_d  = rx_cnt_q - 1'b1;
					end
				end
				OP_XCHG: begin
					if (armed_q) begin
						armed_d = 1'b0;
						v       = ~cmd.data_byte;
						store   = 1'b1;
					end else if (cmd.data_byte == IDLE_BYTE) begin
						store = 1'b0;
					end else if (cmd.data_byte == ESC_BYTE) begin
						armed_d = 1'b1;
					end else if (cmd.data_byte == ZERO_BYTE || cmd.data_byte == ONES_BYTE) begin
						flags_d = flags_q | FLAG_LINE;
					end else begin
						store = 1'b1;
					end
					if (store) begin
						if (rx_cnt_q == CNT_FULL) begin
							flags_d = flags_q | FLAG_OVF;
						end else begin
							rx_we     = 1'b1;
							rx_wptr_d = ptr_next(rx_wptr_q);
							rx_cnt_d  = rx_cnt_q + 1'b1;
							flags_d   = '0;
						end
					end
					hold_d = '0;
					if (hold_eff != '0) begin
						s1_d.direct = hold_eff;
					end else if (tx_cnt_q == '0) begin
						s1_d.direct = IDLE_BYTE;
					end else begin
						tx_re     = 1'b1;
						s1_d.src  = SRC_TX;
						tx_rptr_d = ptr_next(tx_rptr_q);
						tx_cnt_d  = tx_cnt_q - 1'b1;
					end
					s1_d.start = !role_q;
					act_d      = 1'b1;
				end
				OP_TICK: begin
					if (role_q) begin
						s1_d.start = !cmd.transfer_busy;
					end else if (act_q) begin
						act_d  = 1'b0;
						idle_d = '0;
					end else begin
						idle_d = (idle_q != IDLE_MAX) ? idle_q + 1'b1 : idle_q;
						if (idle_d >= IDLE_LIMIT) begin
							flags_d = flags_q | FLAG_TIMEOUT;
						end
					end
				end
				OP_CLEAR: begin
					tx_wptr_d = '0;
					tx_rptr_d = '0;
					tx_cnt_d  = '0;
					rx_wptr_d = '0;
					rx_rptr_d = '0;
					rx_cnt_d  = '0;
					hold_d    = '0;
					flags_d   = '0;
					armed_d   = 1'b0;
					act_d     = 1'b0;
					idle_d    = '0;
				end
				default: begin
					store = 1'b0;
				end
			endcase
		end
		rx_wdata      = v;
		s1_d.flags    = flags_d;
		s1_d.rx_level = LVL_W'(rx_cnt_d);
		s1_d.tx_level = LVL_W'(tx_cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wptr_q <= '0;
			tx_rptr_q <= '0;
			tx_cnt_q  <= '0;
			rx_wptr_q <= '0;
			rx_rptr_q <= '0;
			rx_cnt_q  <= '0;
			hold_q    <= '0;
			flags_q   <= '0;
			armed_q   <= 1'b0;
			act_q     <= 1'b0;
			idle_q    <= '0;
			role_q    <= 1'b0;
			s1_valid  <= 1'b0;
		end else begin
			tx_wptr_q <= tx_wptr_d;
			tx_rptr_q <= tx_rptr_d;
			tx_cnt_q  <= tx_cnt_d;
			rx_wptr_q <= rx_wptr_d;
			rx_rptr_q <= rx_rptr_d;
			rx_cnt_q  <= rx_cnt_d;
			hold_q    <= hold_d;
			flags_q   <= flags_d;
			armed_q   <= armed_d;
			act_q     <= act_d;
			idle_q    <= idle_d;
			if (cfg_we) begin
				role_q <= cfg_wdata;
			end
			if (acc) begin
				s1_valid <= 1'b1;
			end else if (s1_take) begin
				s1_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_s1 <= s1_d;
		end
	end

	`SSLU_ASSERT_ALWAYS(a_cnt_bound, (tx_cnt_q <= CNT_FULL) && (rx_cnt_q <= CNT_FULL), "ring count past capacity")
	`SSLU_ASSERT_SAME(a_hold_vs_pop, s1_valid && (s1_s1.src == SRC_TX), hold_q == '0, "escape held while ring pop in flight")
	`SSLU_ASSERT_NEXT(a_clear, acc && (cmd.opcode == OP_CLEAR), (tx_cnt_q == '0) && (rx_cnt_q == '0) && (flags_q == '0) && (hold_q == '0), "clear left state behind")
endmodule
`default_nettype wire

>>> rtl/sslu_out.sv
// Result stage: picks the ring read data or direct byte, encodes, holds the result item.
// Depends on sslu_pkg and sslu_if.
`default_nettype none
module sslu_out (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s1_valid,
	input  wire sslu_pkg::s1_t               s1_s1,
	input  wire logic [sslu_pkg::BYTE_W-1:0] tx_rdata,
	input  wire logic [sslu_pkg::BYTE_W-1:0] rx_rdata,
	output      logic                        s1_take,
	sslu_rsp_if.source                       rsp
);
	import sslu_pkg::*;

	logic              s2_valid_q;
	logic [BYTE_W-1:0] byte_d;

	assign s1_take   = !s2_valid_q || rsp.ready;
	assign rsp.valid = s2_valid_q;

	always_comb begin
		unique case (s1_s1.src)
			SRC_RX:  byte_d = rx_rdata;
			SRC_TX:  byte_d = tx_encode(tx_rdata);
			default: byte_d = s1_s1.direct;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_take) begin
			s2_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && s1_valid) begin
			rsp.out_byte       <= byte_d;
			rsp.status         <= s1_s1.status;
			rsp.error_flags    <= s1_s1.flags;
			rsp.start_transfer <= s1_s1.start;
			rsp.rx_level       <= s1_s1.rx_level;
			rsp.tx_level       <= s1_s1.tx_level;
		end
	end
endmodule
`default_nettype wire

>>> rtl/stuffed_serial_link_engine_unit.sv
// A command item is held in the accept-stage register, then in the result-stage register that drives rsp.
// Throughput: one item per cycle; the ring RAM read latency sets the two stages.
// Back-pressure on rsp stalls both stages; cmd.ready falls only when both are full.
// Reset: pointers, counts, flags, escape and timeout state and link_role clear at once;
// ring contents are left as they are, no clearing pass.
`default_nettype none
module stuffed_serial_link_engine_unit #(
	parameter int RING_DEPTH    = sslu_pkg::RING_DEPTH_DEF,
	parameter int TIMEOUT_TICKS = sslu_pkg::TIMEOUT_TICKS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sslu_cmd_if.sink  cmd,
	sslu_rsp_if.source rsp,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);
	import sslu_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);

	logic              tx_we, tx_re, rx_we, rx_re;
	logic [AW-1:0]     tx_waddr, tx_raddr, rx_waddr, rx_raddr;
	logic [BYTE_W-1:0] rx_wdata, tx_rdata, rx_rdata;
	logic              s1_valid, s1_take;
	s1_t               s1_s1;

	sslu_ctrl #(
		.RING_DEPTH    (RING_DEPTH),
		.TIMEOUT_TICKS (TIMEOUT_TICKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s1_take   (s1_take),
		.tx_rdata  (tx_rdata),
		.tx_we     (tx_we),
		.tx_waddr  (tx_waddr),
		.tx_re     (tx_re),
		.tx_raddr  (tx_raddr),
		.rx_we     (rx_we),
		.rx_waddr  (rx_waddr),
		.rx_wdata  (rx_wdata),
		.rx_re     (rx_re),
		.rx_raddr  (rx_raddr),
		.s1_valid  (s1_valid),
		.s1_s1     (s1_s1)
	);

	sslu_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RING_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (cmd.data_byte),
		.re    (tx_re),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	sslu_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RING_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (rx_wdata),
		.re    (rx_re),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	sslu_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1_s1    (s1_s1),
		.tx_rdata (tx_rdata),
		.rx_rdata (rx_rdata),
		.s1_take  (s1_take),
		.rsp      (rsp)
	);
endmodule
`default_nettype wire

>>> bench/sslu_link_checker.sv
// Checker for the serial link engine: watches cmd, rsp and the role register,
// predicts each result item and compares it field by field.
// Depends on sslu_pkg and the sslu_cmd_if / sslu_rsp_if interfaces.
`timescale 1ns / 1ps
module sslu_link_checker (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sslu_cmd_if         cmd,
	sslu_rsp_if         rsp,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	output int unsigned outstanding,
	output int unsigned mismatches,
	output int unsigned results_seen
);
	import sslu_pkg::*;

	localparam int RING_SLOTS = RING_DEPTH_DEF;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [ST_W-1:0]   status;
		logic [BYTE_W-1:0] flags;
		logic              start;
		logic [LVL_W-1:0]  rx_level;
		logic [LVL_W-1:0]  tx_level;
	} link_result_t;

	logic [BYTE_W-1:0] tx_mem [RING_SLOTS];
	logic [BYTE_W-1:0] rx_mem [RING_SLOTS];
	logic [LVL_W-1:0]  tx_wr, tx_rd, tx_cnt;
	logic [LVL_W-1:0]  rx_wr, rx_rd, rx_cnt;
	logic [BYTE_W-1:0] esc_hold;
	logic              esc_armed;
	logic [BYTE_W-1:0] flags;
	logic [IDLE_W-1:0] idle_cnt;
	logic              activity;
	logic              link_master;

	link_result_t      expected_q[$];
	link_result_t      got, want;

	function automatic void clear_link();
		tx_wr = '0; tx_rd = '0; tx_cnt = '0;
		rx_wr = '0; rx_rd = '0; rx_cnt = '0;
		esc_hold = '0; esc_armed = 1'b0; flags = '0;
		idle_cnt = '0; activity = 1'b0;
	endfunction

	function automatic link_result_t predict_link(input logic [OP_W-1:0] op,
		input logic [BYTE_W-1:0] b, input logic busy);
		link_result_t      res;
		logic [BYTE_W-1:0] v, raw, enc;
		logic              have;
		res = '0;
		v = '0;
		have = 1'b0;
		case (op)
			OP_PUSH: begin
				if (tx_wr + 5'd1 == tx_rd) begin
					res.status = ST_FULL;
				end else begin
					tx_mem[tx_wr] = b;
					tx_wr++;
					tx_cnt++;
				end
			end
			OP_POP: begin
				if (rx_cnt == 0) begin
					res.out_byte = flags;
					res.status = (flags != 0) ? ST_EMPTY_ERR : ST_EMPTY;
				end else begin
					rx_cnt--;
					res.out_byte = rx_mem[rx_rd];
					rx_rd++;
				end
			end
			OP_XCHG: begin
				// receive side
				if (esc_armed) begin
					esc_armed = 1'b0;
					v = ~b;
					have = 1'b1;
				end else if (b == IDLE_BYTE) begin
					have = 1'b0;
				end else if (b == ESC_BYTE) begin
					esc_armed = 1'b1;
				end else if (b == ZERO_BYTE || b == ONES_BYTE) begin
					flags = flags | FLAG_LINE;
				end else begin
					v = b ^ XOR_MASK;
					have = 1'b1;
				end
				if (have) begin
					if (rx_wr + 5'd1 == rx_rd) begin
						flags = flags | FLAG_OVF;
					end else begin
						rx_mem[rx_wr] = v;
						rx_wr++;
						rx_cnt++;
						flags = '0;
					end
				end
				// send side
				if (esc_hold != 0) begin
					res.out_byte = esc_hold;
					esc_hold = '0;
				end else if (tx_cnt == 0) begin
					res.out_byte = IDLE_BYTE;
				end else begin
					tx_cnt--;
					raw = tx_mem[tx_rd];
					tx_rd++;
					enc = raw ^ XOR_MASK;
					if (enc == IDLE_BYTE || enc == ESC_BYTE || enc == ONES_BYTE ||
						enc == ZERO_BYTE) begin
						esc_hold = ~raw;
						res.out_byte = ESC_BYTE;
					end else begin
						res.out_byte = enc;
					end
				end
				res.start = !link_master;
				activity = 1'b1;
			end
			OP_TICK: begin
				if (link_master) begin
					res.start = !busy;
				end else if (activity) begin
					activity = 1'b0;
					idle_cnt = '0;
				end else begin
					if (idle_cnt != IDLE_MAX)
						idle_cnt++;
					if (idle_cnt >= TIMEOUT_TICKS_DEF)
						flags = flags | FLAG_TIMEOUT;
				end
			end
			OP_CLEAR: begin
				clear_link();
			end
			default: begin
				have = 1'b0;
			end
		endcase
		res.flags = flags;
		res.rx_level = rx_cnt;
		res.tx_level = tx_cnt;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_link();
			link_master = 1'b0;
			expected_q.delete();
			outstanding <= 0;
			mismatches = 0;
			results_seen = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				got.out_byte = rsp.out_byte;
				got.status = rsp.status;
				got.flags = rsp.error_flags;
				got.start = rsp.start_transfer;
				got.rx_level = rsp.rx_level;
				got.tx_level = rsp.tx_level;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result item with nothing expected: byte %02h status %0d",
							$time, got.out_byte, got.status);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch, expected byte %02h st %0d flags %02h start %0b rx %0d tx %0d",
								$time, want.out_byte, want.status, want.flags, want.start,
								want.rx_level, want.tx_level);
							$display("%0t:                got byte %02h st %0d flags %02h start %0b rx %0d tx %0d",
								$time, got.out_byte, got.status, got.flags, got.start,
								got.rx_level, got.tx_level);
						end
					end
				end
			end
			if (cfg_we)
				link_master = cfg_wdata;
			if (cmd.valid && cmd.ready)
				expected_q.push_back(predict_link(cmd.opcode, cmd.data_byte, cmd.transfer_busy));
			outstanding <= expected_q.size();
		end
	end

endmodule

>>> bench/stuffed_serial_link_engine_unit_test.sv
// Top of the serial link engine bench: clock, reset, role writes and command
// stimulus with random gaps and result back-pressure; verdict from the checker.
// Depends on sslu_pkg, the channel interfaces, the engine and sslu_link_checker.
`timescale 1ns / 1ps
module stuffed_serial_link_engine_unit_test;
	import sslu_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam logic            ROLE_SLAVE  = 1'b0;
	localparam logic            ROLE_MASTER = 1'b1;
	localparam int              PHASES      = 6;
	localparam int              PHASE_ITEMS = 320;
	localparam int              DRAIN_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	int unsigned outstanding, mismatches, results_seen;
	int unsigned sent [5];
	int unsigned spare_sent;
	int unsigned ready_left;
	bit          gaps_on;

	sslu_cmd_if cmd_ch();
	sslu_rsp_if rsp_ch();

	stuffed_serial_link_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	sslu_link_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.rsp          (rsp_ch),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.outstanding  (outstanding),
		.mismatches   (mismatches),
		.results_seen (results_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#8_000_000;
		$display("** stuffed_serial_link_engine_unit: FAILED **");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// host bytes, biased toward the ones that need escaping on the wire
	function automatic logic [BYTE_W-1:0] pick_host();
		case ($urandom_range(0, 9))
			0: return IDLE_BYTE ^ XOR_MASK;
			1: return ESC_BYTE ^ XOR_MASK;
			2: return ONES_BYTE ^ XOR_MASK;
			3: return ZERO_BYTE ^ XOR_MASK;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_wire();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return IDLE_BYTE;
		else if (r < 30)
			return ESC_BYTE;
		else if (r < 35)
			return ZERO_BYTE;
		else if (r < 40)
			return ONES_BYTE;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// result back-pressure: runs of ready and stalls, some long open stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			ready_left = 0;
		end else if (ready_left != 0) begin
			ready_left--;
		end else begin
			case ($urandom_range(0, 19))
				0, 1: begin
					rsp_ch.ready <= 1'b1;
					ready_left = $urandom_range(100, 300);
				end
				2, 3, 4, 5, 6, 7, 8, 9, 10: begin
					rsp_ch.ready <= 1'b1;
					ready_left = $urandom_range(0, 8);
				end
				default: begin
					rsp_ch.ready <= 1'b0;
					ready_left = pick_gap();
				end
			endcase
		end
	end

	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
		input logic busy);
		int unsigned gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.data_byte <= b;
		cmd_ch.transfer_busy <= busy;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (op > OP_CLEAR)
			spare_sent++;
		else
			sent[op]++;
	endtask

	task automatic set_role(input logic role);
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= role;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int unsigned budget);
		int unsigned done, run, kind, k;
		logic [OP_W-1:0] op;
		done = 0;
		while (done < budget) begin
			kind = $urandom_range(0, 99);
			gaps_on = ($urandom_range(0, 3) != 0);
			if (kind < 15)
				run = $urandom_range(10, 40);
			else if (kind < 40)
				run = $urandom_range(5, 45);
			else if (kind < 55)
				run = $urandom_range(5, 35);
			else if (kind < 65)
				run = $urandom_range(1, 12);
			else if (kind < 69)
				run = 1;
			else
				run = $urandom_range(5, 30);
			repeat (run) begin
				if (kind < 15) begin
					op = OP_PUSH;
				end else if (kind < 40) begin
					op = OP_XCHG;
				end else if (kind < 55) begin
					op = OP_POP;
				end else if (kind < 65) begin
					op = OP_TICK;
				end else if (kind < 67) begin
					op = OP_CLEAR;
				end else if (kind < 69) begin
					op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				end else begin
					k = $urandom_range(0, 99);
					if (k < 25)
						op = OP_PUSH;
					else if (k < 50)
						op = OP_POP;
					else if (k < 85)
						op = OP_XCHG;
					else if (k < 98)
						op = OP_TICK;
					else if (k < 99)
						op = OP_CLEAR;
					else
						op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				end
				send_cmd(op, (op == OP_XCHG) ? pick_wire() : pick_host(),
					1'($urandom_range(0, 1)));
			end
			done += run;
		end
	endtask

	initial begin
		int unsigned waited;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= ROLE_SLAVE;
		cmd_ch.valid <= 1'b0;
		cmd_ch.opcode <= OP_PUSH;
		cmd_ch.data_byte <= '0;
		cmd_ch.transfer_busy <= 1'b0;
		spare_sent = 0;
		foreach (sent[i])
			sent[i] = 0;
		gaps_on = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_role(ROLE_SLAVE);

		// directed: empty pop, escaped sends, wire decoding, timeout saturation
		send_cmd(OP_POP, ZERO_BYTE, 1'b0);
		send_cmd(OP_PUSH, ZERO_BYTE, 1'b0);
		send_cmd(OP_PUSH, ONES_BYTE, 1'b1);
		send_cmd(OP_PUSH, IDLE_BYTE ^ XOR_MASK, 1'b0);
		send_cmd(OP_PUSH, ESC_BYTE ^ XOR_MASK, 1'b0);
		send_cmd(OP_PUSH, ONES_BYTE ^ XOR_MASK, 1'b0);
		send_cmd(OP_PUSH, ZERO_BYTE ^ XOR_MASK, 1'b0);
		send_cmd(OP_XCHG, IDLE_BYTE, 1'b0);
		send_cmd(OP_XCHG, ESC_BYTE, 1'b0);
		send_cmd(OP_XCHG, IDLE_BYTE, 1'b0);
		send_cmd(OP_XCHG, ZERO_BYTE, 1'b0);
		send_cmd(OP_XCHG, ONES_BYTE, 1'b0);
		send_cmd(OP_POP, ONES_BYTE, 1'b0);
		send_cmd(OP_POP, ZERO_BYTE, 1'b0);
		send_cmd(OP_XCHG, ESC_BYTE, 1'b0);
		send_cmd(OP_XCHG, ESC_BYTE, 1'b0);
		repeat (8) send_cmd(OP_TICK, ZERO_BYTE, 1'b1);
		send_cmd(OP_SPARE_HI, ONES_BYTE, 1'b1);
		send_cmd(OP_CLEAR, ZERO_BYTE, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			set_role((p % 2 == 0) ? ROLE_MASTER : ROLE_SLAVE);
			random_phase(PHASE_ITEMS);
		end

		cmd_ch.valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (outstanding != 0)
			$display("%0d result items never arrived", outstanding);

		$display("run covered %0d push, %0d pop, %0d exchange, %0d tick, %0d clear, %0d spare items",
			sent[OP_PUSH], sent[OP_POP], sent[OP_XCHG], sent[OP_TICK], sent[OP_CLEAR],
			spare_sent);
		$display("%0d result items compared over both link roles, %0d mismatching",
			results_seen, mismatches);
		if (mismatches == 0 && outstanding == 0) begin
			$display("** stuffed_serial_link_engine_unit: PASSED **");
		end else begin
			$display("** stuffed_serial_link_engine_unit: FAILED **");
		end
		$finish;
	end

endmodule
